/* rtl/hsa_pkg.sv */
// Shared types and constants for the handle slot allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsa_pkg;

	localparam int SLOTS_DEF    = 64;
	localparam int RESERVED_DEF = 2;

	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 7;
	localparam int HANDLE_W = 32;
	localparam int SLOTO_W  = 6;
	localparam int STATUS_W = 2;

	localparam int IN_W  = 48;  // cmd + slot + handle, padded to bytes
	localparam int OUT_W = 40;  // slot_out + handle_out + status

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLOSE  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_NULL = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

endpackage

`default_nettype wire

/* rtl/handle_slot_allocator_unit.sv */
// Top level of the handle slot allocator: input stage, slot table, result register.
// Depends on hsa_pkg and hsa_find_free.
//
// Usage:
//   One command word enters on the s_axis channel (allocate, lookup, close) and
//   exactly one result word leaves on the m_axis channel for each, in order.
//   Allocate stores a nonzero handle in the lowest free slot and returns that
//   slot; lookup returns the handle held in a slot; close empties the slot and
//   returns the handle it held so the caller can release it.
// Pipeline and throughput:
//   An accepted command and its table read are registered in the input stage
//   and decoded there; the result register loads the result word when the
//   input stage advances. One command per cycle is taken while the output side
//   keeps tready high; the table updates when a command leaves the input stage,
//   and a read that hits the slot written in that same cycle is forwarded.
// Reset:
//   arst_n clears the slot valid map, so every slot reads empty; the lowest
//   RESERVED slots are masked and never granted. Table data is left as is; no sweep.
// Stall:
//   When m_axis_tready is low the result register holds its word and the input
//   stage holds one more command; s_axis_tready then drops until space frees.
`default_nettype none

module handle_slot_allocator_unit
	import hsa_pkg::*;
#(
	parameter int SLOTS    = SLOTS_DEF,
	parameter int RESERVED = RESERVED_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// [1:0] cmd, [8:2] slot, [40:9] handle, [47:41] zero
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// [5:0] slot_out, [37:6] handle_out, [39:38] status
	output logic [OUT_W-1:0]      m_axis_tdata
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int DEPTH = 1 << IDX_W;
	localparam logic [SLOT_W-1:0] SLOTS_L = SLOT_W'(SLOTS);

	// input fields
	logic [CMD_W-1:0]    in_cmd;
	logic [SLOT_W-1:0]   in_slot;
	logic [HANDLE_W-1:0] in_handle;

	assign in_cmd    = s_axis_tdata[1:0];
	assign in_slot   = s_axis_tdata[8:2];
	assign in_handle = s_axis_tdata[40:9];

	// input stage
	logic                v_s1;
	cmd_t                cmd_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [HANDLE_W-1:0] rd_s1;
	logic                byp_s1;
	logic [HANDLE_W-1:0] byp_data_s1;

	// table state
	logic [HANDLE_W-1:0] mem [DEPTH];
	logic [SLOTS-1:0]    vld_q;
	logic [SLOTS-1:0]    res_mask;

	// result register
	logic                out_v_q;
	logic [OUT_W-1:0]    out_q;

	logic                s_acc;
	logic                advance;
	logic [SLOTS-1:0]    free_map;
	logic                free_found;
	logic [IDX_W-1:0]    grant_idx;

	logic                wr_en;
	logic                clr_en;
	logic [IDX_W-1:0]    idx_s1;
	logic [HANDLE_W-1:0] held;
	logic [SLOTO_W-1:0]  r_slot;
	logic [HANDLE_W-1:0] r_handle;
	status_t             r_status;

	// advance the input stage whenever the result register is free or draining
	assign advance       = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			res_mask[i] = (i < RESERVED);
		end
	end

	// reserved slots never become valid, so mask them out of the free map
	assign free_map = ~vld_q & ~res_mask;

	hsa_find_free #(
		.N     (SLOTS),
		.IDX_W (IDX_W)
	) u_find (
		.free_map (free_map),
		.found    (free_found),
		.idx      (grant_idx)
	);

	assign idx_s1 = slot_s1[IDX_W-1:0];
	assign held   = byp_s1 ? byp_data_s1 : rd_s1;

	// command decode and result build
	always_comb begin
		wr_en    = 1'b0;
		clr_en   = 1'b0;
		r_slot   = slot_s1[SLOTO_W-1:0];
		r_handle = '0;
		r_status = ST_NONE;
		case (cmd_s1)
			CMD_ALLOC: begin
				r_slot = '0;
				if (handle_s1 == '0) begin
					r_status = ST_NULL;
				end else if (!free_found) begin
					r_status = ST_FULL;
				end else begin
					r_status = ST_OK;
					r_slot   = SLOTO_W'(grant_idx);
					wr_en    = advance;
				end
			end
			CMD_LOOKUP, CMD_CLOSE: begin
				if (slot_s1 >= SLOTS_L) begin
					r_status = ST_NONE;
				end else if (!vld_q[idx_s1]) begin
					r_status = ST_NONE;
				end else begin
					r_status = ST_OK;
					r_handle = held;
					clr_en   = advance && (cmd_s1 == CMD_CLOSE);
				end
			end
			default: begin
				r_status = ST_NONE;
			end
		endcase
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	// input stage payload, table read and write-through forwarding
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1      <= cmd_t'(in_cmd);
			slot_s1     <= in_slot;
			handle_s1   <= in_handle;
			byp_s1      <= wr_en && (grant_idx == in_slot[IDX_W-1:0]);
			byp_data_s1 <= handle_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_s1 <= mem[in_slot[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[grant_idx] <= handle_s1;
		end
	end

	// valid map: set on grant, clear on close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (wr_en) begin
				vld_q[grant_idx] <= 1'b1;
			end
			if (clr_en) begin
				vld_q[idx_s1] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {r_status, r_handle, r_slot};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

/* rtl/hsa_find_free.sv */
// Lowest-set-bit priority encoder over the free slot map.
// Depends on hsa_pkg for the default slot count SLOTS_DEF.
`default_nettype none

module hsa_find_free
	import hsa_pkg::*;
#(
	parameter int N     = SLOTS_DEF,
	parameter int IDX_W = $clog2(N)
) (
	input  wire logic [N-1:0]     free_map,
	output logic                  found,
	output logic [IDX_W-1:0]      idx
);

	// scan from the top so the lowest free bit wins
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (free_map[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/hsa_checker.sv */
// Port-level checks for the handle slot allocator, bound to its top level.
// Depends on hsa_pkg and handle_slot_allocator_unit.
`default_nettype none

module hsa_checker
	import hsa_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// rejected or full allocate carries no slot and no handle
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[39:38] == ST_NULL || m_axis_tdata[39:38] == ST_FULL)
		|-> m_axis_tdata[37:0] == '0)
		else $error("rejected allocate returned slot or handle");

	// empty or out-of-range slot never returns a handle
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[39:38] == ST_NONE |-> m_axis_tdata[37:6] == '0)
		else $error("handle returned with empty status");

	// an accepted command reaches the output once the output side is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result word missing after accepted command");

endmodule

bind handle_slot_allocator_unit hsa_checker u_hsa_checker (.*);

`default_nettype wire
